>>> hw/rtl/fsbc_pkg.sv
// Package for the size-budgeted FIFO cache: sizes, codes and shared types.
// Used by every module of the cache.
`timescale 1ns / 1ps
package fsbc_pkg;

  localparam int ENTRIES  = 16;
  localparam int PTR_W    = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int SLOT_W   = 4;
  localparam int IDENT_W  = 32;
  localparam int SIZE_W   = 24;
  localparam int HANDLE_W = 32;
  localparam int BUDGET_W = 28;
  localparam int TOTAL_W  = 29;

  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 28'd1048576;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_REMOVE = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    KIND_FREED  = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_REMOVE = 2'd3
  } kind_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_EV_ACT,
    S_WR_RD,
    S_WR_ACT,
    S_WR_ST,
    S_LK_ACT,
    S_RM_ACT,
    S_RM_DONE
  } state_t;

  typedef struct packed {
    logic [PTR_W-1:0]          raddr;
    logic                      we;
    logic [PTR_W-1:0]          waddr;
    logic [HANDLE_W-1:0]       w_handle;
    logic [SIZE_W-1:0]         w_size;
    logic signed [IDENT_W-1:0] w_ident;
    logic                      vclr;
    logic [PTR_W-1:0]          vclr_addr;
  } st_ctl_t;

  typedef struct packed {
    kind_t               kind;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] handle;
    logic                hit;
    logic                last;
  } res_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(ENTRIES - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

>>> hw/rtl/fifo_size_budget_cache_core.sv
// Size-budgeted FIFO cache, top level. One request at a time; in_ready is
// high only while idle. An add may take eviction steps first (at most ENTRIES
// steps), and each result waits until the result register accepts it.
// Each step of the sequencer uses the one shared size unit.
// Synchronous active-low reset clears all slots, pointers and the total and
// sets the budget to 1048576; slot contents are not cleared.
`timescale 1ns / 1ps
module fifo_size_budget_cache_core import fsbc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [BUDGET_W-1:0]       cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_req_type,
  input  logic [SLOT_W-1:0]         in_slot_index,
  input  logic signed [IDENT_W-1:0] in_ident,
  input  logic [SIZE_W-1:0]         in_elem_size,
  input  logic [HANDLE_W-1:0]       in_data_handle,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_result_kind,
  output logic [SLOT_W-1:0]         out_slot,
  output logic [HANDLE_W-1:0]       out_handle_out,
  output logic                      out_hit,
  output logic                      out_last
);

  logic [BUDGET_W-1:0]       budget_r;
  alu_op_t                   alu_op;
  logic [TOTAL_W-1:0]        alu_a, alu_sum;
  logic [SIZE_W-1:0]         alu_b;
  logic                      alu_over;
  st_ctl_t                   st_ctl;
  logic [HANDLE_W-1:0]       rd_handle;
  logic [SIZE_W-1:0]         rd_size;
  logic signed [IDENT_W-1:0] rd_ident;
  logic [ENTRIES-1:0]        valid_vec;
  logic                      emit_valid, emit_ready;
  res_t                      emit_res, out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= BUDGET_RESET;
    end else if (cfg_wr_en) begin
      budget_r <= cfg_wr_data;
    end
  end

  fsbc_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_slot_index  (in_slot_index),
    .in_ident       (in_ident),
    .in_elem_size   (in_elem_size),
    .in_data_handle (in_data_handle),
    .alu_op         (alu_op),
    .alu_a          (alu_a),
    .alu_b          (alu_b),
    .alu_sum        (alu_sum),
    .alu_over       (alu_over),
    .st_ctl         (st_ctl),
    .rd_handle      (rd_handle),
    .rd_size        (rd_size),
    .rd_ident       (rd_ident),
    .valid_vec      (valid_vec),
    .emit_valid     (emit_valid),
    .emit_res       (emit_res),
    .emit_ready     (emit_ready)
  );

  fsbc_alu u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .budget (budget_r),
    .sum    (alu_sum),
    .over   (alu_over)
  );

  fsbc_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (st_ctl),
    .rd_handle (rd_handle),
    .rd_size   (rd_size),
    .rd_ident  (rd_ident),
    .valid_vec (valid_vec)
  );

  fsbc_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit_valid (emit_valid),
    .emit_res   (emit_res),
    .emit_ready (emit_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (out_res)
  );

  assign out_result_kind = out_res.kind;
  assign out_slot        = out_res.slot;
  assign out_handle_out  = out_res.handle;
  assign out_hit         = out_res.hit;
  assign out_last        = out_res.last;

endmodule

>>> hw/rtl/fsbc_store.sv
// Slot store: handle, size and identifier memories with registered read,
// plus per-slot valid flags. Depends on fsbc_pkg.
`timescale 1ns / 1ps
module fsbc_store import fsbc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  st_ctl_t                   ctl,
  output logic [HANDLE_W-1:0]       rd_handle,
  output logic [SIZE_W-1:0]         rd_size,
  output logic signed [IDENT_W-1:0] rd_ident,
  output logic [ENTRIES-1:0]        valid_vec
);

  logic [HANDLE_W-1:0]       mem_handle [ENTRIES];
  logic [SIZE_W-1:0]         mem_size   [ENTRIES];
  logic signed [IDENT_W-1:0] mem_ident  [ENTRIES];
  logic [ENTRIES-1:0]        valid_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem_handle[ctl.waddr] <= ctl.w_handle;
      mem_size[ctl.waddr]   <= ctl.w_size;
      mem_ident[ctl.waddr]  <= ctl.w_ident;
    end
    rd_handle <= mem_handle[ctl.raddr];
    rd_size   <= mem_size[ctl.raddr];
    rd_ident  <= mem_ident[ctl.raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.we) begin
      valid_r[ctl.waddr] <= 1'b1;
    end else if (ctl.vclr) begin
      valid_r[ctl.vclr_addr] <= 1'b0;
    end
  end

  assign valid_vec = valid_r;

endmodule

>>> hw/rtl/fsbc_alu.sv
// Shared size unit: adds or subtracts a block size on the running total and
// compares total plus size against the budget. Depends on fsbc_pkg.
`timescale 1ns / 1ps
module fsbc_alu import fsbc_pkg::*; (
  input  alu_op_t             op,
  input  logic [TOTAL_W-1:0]  a,
  input  logic [SIZE_W-1:0]   b,
  input  logic [BUDGET_W-1:0] budget,
  output logic [TOTAL_W-1:0]  sum,
  output logic                over
);

  logic [TOTAL_W:0] wide;

  always_comb begin
    unique case (op)
      ALU_ADD: wide = {1'b0, a} + (TOTAL_W + 1)'(b);
      ALU_SUB: wide = {1'b0, a} - (TOTAL_W + 1)'(b);
      default: wide = '0;
    endcase
  end

  assign sum  = wide[TOTAL_W-1:0];
  assign over = (op == ALU_ADD) && (wide > (TOTAL_W + 1)'(budget));

endmodule

>>> hw/rtl/fsbc_seq.sv
// Request sequencer: pointers, running total and eviction walk, one step at
// a time over the shared size unit. Depends on fsbc_pkg.
`timescale 1ns / 1ps
module fsbc_seq import fsbc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_req_type,
  input  logic [SLOT_W-1:0]         in_slot_index,
  input  logic signed [IDENT_W-1:0] in_ident,
  input  logic [SIZE_W-1:0]         in_elem_size,
  input  logic [HANDLE_W-1:0]       in_data_handle,
  output alu_op_t                   alu_op,
  output logic [TOTAL_W-1:0]        alu_a,
  output logic [SIZE_W-1:0]         alu_b,
  input  logic [TOTAL_W-1:0]        alu_sum,
  input  logic                      alu_over,
  output st_ctl_t                   st_ctl,
  input  logic [HANDLE_W-1:0]       rd_handle,
  input  logic [SIZE_W-1:0]         rd_size,
  input  logic signed [IDENT_W-1:0] rd_ident,
  input  logic [ENTRIES-1:0]        valid_vec,
  output logic                      emit_valid,
  output res_t                      emit_res,
  input  logic                      emit_ready
);

  state_t                    state_r, state_nxt;
  logic [PTR_W-1:0]          kill_r, add_r;
  logic [TOTAL_W-1:0]        total_r;
  logic [CNT_W-1:0]          steps_r;
  logic                      freed_r;
  logic [SLOT_W-1:0]         idx_r;
  logic signed [IDENT_W-1:0] ident_r;
  logic [SIZE_W-1:0]         size_r;
  logic [HANDLE_W-1:0]       handle_r;

  logic             go;
  logic             idx_ok;
  logic [PTR_W-1:0] idx_p;
  logic             kill_vld, add_vld, idx_vld;
  logic             lk_hit;

  assign idx_ok   = 32'(idx_r) < ENTRIES;
  assign idx_p    = PTR_W'(idx_r);
  assign kill_vld = valid_vec[kill_r];
  assign add_vld  = valid_vec[add_r];
  assign idx_vld  = idx_ok && valid_vec[idx_p];
  assign lk_hit   = idx_vld && (rd_ident == ident_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_req_type)
            REQ_ADD:    state_nxt = S_CHK;
            REQ_LOOKUP: state_nxt = S_LK_ACT;
            REQ_REMOVE: state_nxt = S_RM_ACT;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_CHK: begin
        state_nxt = (steps_r < CNT_W'(ENTRIES) && alu_over) ? S_EV_ACT : S_WR_RD;
      end
      S_EV_ACT:  if (go) state_nxt = S_CHK;
      S_WR_RD:   state_nxt = S_WR_ACT;
      S_WR_ACT:  if (go) state_nxt = S_WR_ST;
      S_WR_ST:   if (go) state_nxt = S_IDLE;
      S_LK_ACT:  if (go) state_nxt = S_IDLE;
      S_RM_ACT:  if (go) state_nxt = S_RM_DONE;
      S_RM_DONE: if (go) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready           = 1'b0;
    go                 = 1'b0;
    alu_op             = ALU_ADD;
    alu_a              = total_r;
    alu_b              = size_r;
    st_ctl             = '0;
    st_ctl.waddr       = add_r;
    st_ctl.w_handle    = handle_r;
    st_ctl.w_size      = size_r;
    st_ctl.w_ident     = ident_r;
    st_ctl.raddr       = kill_r;
    emit_valid         = 1'b0;
    emit_res.kind      = KIND_FREED;
    emit_res.slot      = '0;
    emit_res.handle    = '0;
    emit_res.hit       = 1'b0;
    emit_res.last      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        st_ctl.raddr = PTR_W'(in_slot_index);
      end
      S_CHK: begin
        st_ctl.raddr = kill_r;
      end
      S_EV_ACT: begin
        alu_op          = ALU_SUB;
        alu_b           = rd_size;
        emit_valid      = kill_vld;
        emit_res.slot   = SLOT_W'(kill_r);
        emit_res.handle = rd_handle;
        go              = !kill_vld || emit_ready;
        st_ctl.vclr     = kill_vld && emit_ready;
        st_ctl.vclr_addr = kill_r;
      end
      S_WR_RD: begin
        st_ctl.raddr = add_r;
      end
      S_WR_ACT: begin
        st_ctl.raddr     = add_r;
        alu_op           = ALU_SUB;
        alu_b            = rd_size;
        emit_valid       = add_vld;
        emit_res.slot    = SLOT_W'(add_r);
        emit_res.handle  = rd_handle;
        go               = !add_vld || emit_ready;
        st_ctl.vclr      = add_vld && emit_ready;
        st_ctl.vclr_addr = add_r;
      end
      S_WR_ST: begin
        emit_valid    = 1'b1;
        emit_res.kind = KIND_ADD;
        emit_res.slot = SLOT_W'(add_r);
        emit_res.last = 1'b1;
        go            = emit_ready;
        st_ctl.we     = emit_ready;
      end
      S_LK_ACT: begin
        st_ctl.raddr    = idx_p;
        emit_valid      = 1'b1;
        emit_res.kind   = KIND_LOOKUP;
        emit_res.slot   = idx_r;
        emit_res.handle = lk_hit ? rd_handle : '0;
        emit_res.hit    = lk_hit;
        emit_res.last   = 1'b1;
        go              = emit_ready;
      end
      S_RM_ACT: begin
        st_ctl.raddr     = idx_p;
        alu_op           = ALU_SUB;
        alu_b            = rd_size;
        emit_valid       = idx_vld;
        emit_res.slot    = idx_r;
        emit_res.handle  = rd_handle;
        go               = !idx_vld || emit_ready;
        st_ctl.vclr      = idx_vld && emit_ready;
        st_ctl.vclr_addr = idx_p;
      end
      S_RM_DONE: begin
        emit_valid    = 1'b1;
        emit_res.kind = KIND_REMOVE;
        emit_res.slot = idx_r;
        emit_res.hit  = freed_r;
        emit_res.last = 1'b1;
        go            = emit_ready;
      end
      default: begin
        go = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kill_r  <= '0;
      add_r   <= '0;
      total_r <= '0;
      steps_r <= '0;
      freed_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          steps_r <= '0;
          freed_r <= 1'b0;
        end
        S_EV_ACT: begin
          if (go) begin
            if (kill_vld) total_r <= alu_sum;
            kill_r  <= ptr_inc(kill_r);
            steps_r <= steps_r + CNT_W'(1);
          end
        end
        S_WR_ACT: begin
          if (go && add_vld) begin
            total_r <= alu_sum;
            kill_r  <= ptr_inc(kill_r);
          end
        end
        S_WR_ST: begin
          if (go) begin
            total_r <= alu_sum;
            add_r   <= ptr_inc(add_r);
          end
        end
        S_RM_ACT: begin
          if (go && idx_vld) begin
            total_r <= alu_sum;
            freed_r <= 1'b1;
          end
        end
        default: begin
          freed_r <= freed_r;
        end
      endcase
    end
  end

  // hold the request word
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      idx_r    <= in_slot_index;
      ident_r  <= in_ident;
      size_r   <= in_elem_size;
      handle_r <= in_data_handle;
    end
  end

endmodule

>>> hw/rtl/fsbc_out.sv
// Result register: holds one result word until the consumer takes it.
// Depends on fsbc_pkg.
`timescale 1ns / 1ps
module fsbc_out import fsbc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic emit_valid,
  input  res_t emit_res,
  output logic emit_ready,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic valid_r;
  res_t res_r;

  assign emit_ready = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (emit_valid && emit_ready) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid && emit_ready) begin
      res_r <= emit_res;
    end
  end

endmodule

>>> tb/sv/tb_top.sv
// Self-checking bench for fifo_size_budget_cache_core: a directed table, then random requests
// under several size budgets, each word checked against its table row or a cache predictor.
// Depends on fsbc_pkg and the core RTL only.
`timescale 1ns / 1ps
module tb_top;
  import fsbc_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_AFTER = 150;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 50;
  localparam longint TIMEOUT_NS = 5_000_000;

  typedef struct packed {
    logic [1:0]          req;
    logic [SLOT_W-1:0]   idx;
    logic [IDENT_W-1:0]  ident;
    logic [SIZE_W-1:0]   size;
    logic [HANDLE_W-1:0] handle;
    logic                typed;
    res_t                want;
  } vector_t;

  localparam res_t NO_WANT = '{KIND_FREED, 4'h0, 32'h0, 1'b0, 1'b0};

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_wr_en = 1'b0;
  logic [BUDGET_W-1:0]       cfg_wr_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                in_req_type = '0;
  logic [SLOT_W-1:0]         in_slot_index = '0;
  logic signed [IDENT_W-1:0] in_ident = '0;
  logic [SIZE_W-1:0]         in_elem_size = '0;
  logic [HANDLE_W-1:0]       in_data_handle = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [1:0]                out_result_kind;
  logic [SLOT_W-1:0]         out_slot;
  logic [HANDLE_W-1:0]       out_handle_out;
  logic                      out_hit;
  logic                      out_last;

  fifo_size_budget_cache_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_slot_index(in_slot_index),
    .in_ident(in_ident),
    .in_elem_size(in_elem_size),
    .in_data_handle(in_data_handle),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_result_kind(out_result_kind),
    .out_slot(out_slot),
    .out_handle_out(out_handle_out),
    .out_hit(out_hit),
    .out_last(out_last)
  );

  always #5 clk = ~clk;

  // cache predictor state
  logic [HANDLE_W-1:0] cached_handle [ENTRIES];
  logic [SIZE_W-1:0]   cached_size [ENTRIES];
  logic [IDENT_W-1:0]  cached_ident [ENTRIES];
  logic [ENTRIES-1:0]  cached_live = '0;
  logic [TOTAL_W-1:0]  occupied_total = '0;
  logic [PTR_W-1:0]    kill_ptr = '0;
  logic [PTR_W-1:0]    add_ptr = '0;
  logic [BUDGET_W-1:0] budget_now = BUDGET_RESET;

  res_t step_words[$];
  res_t expected_words[$];
  int   failures = 0;
  int   words_checked = 0;
  int   requests_sent = 0;
  bit   steady = 1'b0;

  vector_t directed_rows [0:24] = '{
    '{REQ_ADD, 4'h0, 32'h80000000, 24'h000000, 32'h00000000, 1'b1,
      '{KIND_ADD, 4'h0, 32'h0, 1'b0, 1'b1}},
    '{REQ_ADD, 4'hF, 32'h7FFFFFFF, 24'h000001, 32'hFFFFFFFF, 1'b1,
      '{KIND_ADD, 4'h1, 32'h0, 1'b0, 1'b1}},
    '{REQ_ADD, 4'h5, 32'h55555555, 24'h005555, 32'hAAAAAAAA, 1'b1,
      '{KIND_ADD, 4'h2, 32'h0, 1'b0, 1'b1}},
    '{REQ_ADD, 4'hA, 32'hAAAAAAAA, 24'h002AAA, 32'h55555555, 1'b1,
      '{KIND_ADD, 4'h3, 32'h0, 1'b0, 1'b1}},
    '{REQ_ADD, 4'h0, 32'h00000004, 24'h000400, 32'h00001004, 1'b1,
      '{KIND_ADD, 4'h4, 32'h0, 1'b0, 1'b1}},
    '{REQ_ADD, 4'h0, 32'h00000005, 24'h000500, 32'h00001005, 1'b1,
      '{KIND_ADD, 4'h5, 32'h0, 1'b0, 1'b1}},
    '{REQ_ADD, 4'h0, 32'h00000006, 24'h000600, 32'h00001006, 1'b1,
      '{KIND_ADD, 4'h6, 32'h0, 1'b0, 1'b1}},
    '{REQ_ADD, 4'h0, 32'h00000007, 24'h000700, 32'h00001007, 1'b1,
      '{KIND_ADD, 4'h7, 32'h0, 1'b0, 1'b1}},
    '{REQ_ADD, 4'h0, 32'h00000008, 24'h000800, 32'h00001008, 1'b1,
      '{KIND_ADD, 4'h8, 32'h0, 1'b0, 1'b1}},
    '{REQ_ADD, 4'h0, 32'h00000009, 24'h000900, 32'h00001009, 1'b1,
      '{KIND_ADD, 4'h9, 32'h0, 1'b0, 1'b1}},
    '{REQ_ADD, 4'h0, 32'h0000000A, 24'h000A00, 32'h0000100A, 1'b1,
      '{KIND_ADD, 4'hA, 32'h0, 1'b0, 1'b1}},
    '{REQ_ADD, 4'h0, 32'h0000000B, 24'h000B00, 32'h0000100B, 1'b1,
      '{KIND_ADD, 4'hB, 32'h0, 1'b0, 1'b1}},
    '{REQ_ADD, 4'h0, 32'h0000000C, 24'h000C00, 32'h0000100C, 1'b1,
      '{KIND_ADD, 4'hC, 32'h0, 1'b0, 1'b1}},
    '{REQ_ADD, 4'h0, 32'h0000000D, 24'h000D00, 32'h0000100D, 1'b1,
      '{KIND_ADD, 4'hD, 32'h0, 1'b0, 1'b1}},
    '{REQ_ADD, 4'h0, 32'h0000000E, 24'h000E00, 32'h0000100E, 1'b1,
      '{KIND_ADD, 4'hE, 32'h0, 1'b0, 1'b1}},
    '{REQ_ADD, 4'h0, 32'hFFFFFFFF, 24'h000F00, 32'h0000100F, 1'b1,
      '{KIND_ADD, 4'hF, 32'h0, 1'b0, 1'b1}},
    '{REQ_LOOKUP, 4'h1, 32'h7FFFFFFF, 24'h000000, 32'h00000000, 1'b1,
      '{KIND_LOOKUP, 4'h1, 32'hFFFFFFFF, 1'b1, 1'b1}},
    '{REQ_LOOKUP, 4'h0, 32'h7FFFFFFF, 24'h000000, 32'h00000000, 1'b1,
      '{KIND_LOOKUP, 4'h0, 32'h0, 1'b0, 1'b1}},
    '{REQ_REMOVE, 4'h5, 32'h00000000, 24'h000000, 32'h00000000, 1'b0, NO_WANT},
    '{REQ_REMOVE, 4'h5, 32'h00000000, 24'h000000, 32'h00000000, 1'b1,
      '{KIND_REMOVE, 4'h5, 32'h0, 1'b0, 1'b1}},
    '{REQ_LOOKUP, 4'h5, 32'h00000005, 24'h000000, 32'h00000000, 1'b1,
      '{KIND_LOOKUP, 4'h5, 32'h0, 1'b0, 1'b1}},
    '{REQ_UNKNOWN, 4'hA, 32'h12345678, 24'hFFFFFF, 32'hFFFFFFFF, 1'b0, NO_WANT},
    '{REQ_ADD, 4'h0, 32'h0BADF00D, 24'hFFFFFF, 32'h12345678, 1'b0, NO_WANT},
    '{REQ_ADD, 4'h3, 32'h00C0FFEE, 24'h000100, 32'hCAFE0001, 1'b0, NO_WANT},
    '{REQ_LOOKUP, 4'h0, 32'h0BADF00D, 24'h000000, 32'h00000000, 1'b1,
      '{KIND_LOOKUP, 4'h0, 32'h0, 1'b0, 1'b1}}
  };

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return PTR_W'((int'(p) + 1) % ENTRIES);
  endfunction

  function automatic void note_word(input kind_t k, input logic [SLOT_W-1:0] s,
                                    input logic [HANDLE_W-1:0] h, input logic hit);
    res_t r;
    r.kind = k;
    r.slot = s;
    r.handle = h;
    r.hit = hit;
    r.last = 1'b0;
    step_words.push_back(r);
  endfunction

  function automatic bit drop_entry(input logic [PTR_W-1:0] s);
    if (!cached_live[s]) return 1'b0;
    note_word(KIND_FREED, SLOT_W'(s), cached_handle[s], 1'b0);
    occupied_total = occupied_total - TOTAL_W'(cached_size[s]);
    cached_live[s] = 1'b0;
    return 1'b1;
  endfunction

  function automatic void predict_request(input logic [1:0] req,
                                          input logic [SLOT_W-1:0] idx,
                                          input logic [IDENT_W-1:0] ident,
                                          input logic [SIZE_W-1:0] size,
                                          input logic [HANDLE_W-1:0] handle);
    longint need;
    logic [PTR_W-1:0] w;
    int steps;
    bit hit;
    step_words.delete();
    case (req)
      REQ_ADD: begin
        need = longint'(budget_now) - longint'(size);
        if (longint'(occupied_total) + longint'(size) > longint'(budget_now)) begin
          steps = 0;
          while (steps < ENTRIES && longint'(occupied_total) > need) begin
            void'(drop_entry(kill_ptr));
            kill_ptr = ring_next(kill_ptr);
            steps++;
          end
        end
        w = add_ptr;
        if (drop_entry(w)) kill_ptr = ring_next(kill_ptr);
        cached_handle[w] = handle;
        cached_size[w] = size;
        cached_ident[w] = ident;
        cached_live[w] = 1'b1;
        occupied_total = occupied_total + TOTAL_W'(size);
        add_ptr = ring_next(add_ptr);
        note_word(KIND_ADD, SLOT_W'(w), '0, 1'b0);
      end
      REQ_LOOKUP: begin
        hit = int'(idx) < ENTRIES && cached_live[idx] && cached_ident[idx] == ident;
        note_word(KIND_LOOKUP, idx, hit ? cached_handle[idx] : '0, hit);
      end
      REQ_REMOVE: begin
        hit = (int'(idx) < ENTRIES) ? drop_entry(PTR_W'(idx)) : 1'b0;
        note_word(KIND_REMOVE, idx, '0, hit);
      end
      default: ;
    endcase
    if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size(input logic [BUDGET_W-1:0] b);
    int unsigned roll;
    int unsigned cap;
    roll = $urandom_range(0, 99);
    cap = (b / 5 > 28'hFFFFFF) ? 32'hFFFFFF : int'(b / 5);
    if (roll < 8) return '0;
    if (roll < 16) return '1;
    if (roll < 26) return SIZE_W'($urandom);
    return SIZE_W'($urandom_range(0, cap));
  endfunction

  task automatic write_budget(input logic [BUDGET_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    budget_now = value;
  endtask

  task automatic offer(input vector_t v);
    if (!steady) begin
      while ($urandom_range(0, 99) < 25) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_req_type <= v.req;
    in_slot_index <= v.idx;
    in_ident <= v.ident;
    in_elem_size <= v.size;
    in_data_handle <= v.handle;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(v.req, v.idx, v.ident, v.size, v.handle);
    if (v.typed) expected_words.push_back(v.want);
    else foreach (step_words[i]) expected_words.push_back(step_words[i]);
    if (v.req != REQ_UNKNOWN) requests_sent++;
  endtask

  // drop valid, wait out all pending words and any trailing work
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_word();
    res_t want;
    words_checked++;
    if (expected_words.size() == 0) begin
      $error("unexpected word: kind %0d slot %0d handle %h", out_result_kind, out_slot,
             out_handle_out);
      failures++;
      return;
    end
    want = expected_words.pop_front();
    if (out_result_kind !== want.kind) begin
      $error("result_kind: expected %0d, actual %0d", want.kind, out_result_kind);
      failures++;
    end
    if (out_slot !== want.slot) begin
      $error("slot: expected %0d, actual %0d", want.slot, out_slot);
      failures++;
    end
    if (out_handle_out !== want.handle) begin
      $error("handle_out: expected %h, actual %h", want.handle, out_handle_out);
      failures++;
    end
    if (out_hit !== want.hit) begin
      $error("hit: expected %0b, actual %0b", want.hit, out_hit);
      failures++;
    end
    if (out_last !== want.last) begin
      $error("last: expected %0b, actual %0b", want.last, out_last);
      failures++;
    end
  endtask

  initial begin : result_sink
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) check_word();
      if (!held && words_checked >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= rst_n && (steady || $urandom_range(0, 99) >= 25);
    end
  end

  initial begin : stimulus
    vector_t v;
    int unsigned roll;
    int n;
    logic [BUDGET_W-1:0] phase_budget [5];
    phase_budget = '{28'hFFFFFFF, 28'd0, 28'd40000, 28'd0, 28'd300000};
    phase_budget[3] = BUDGET_W'($urandom_range(1000, 4000000));
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_budget(BUDGET_RESET);
    foreach (directed_rows[i]) offer(directed_rows[i]);
    settle();
    for (int p = 0; p < 5; p++) begin
      write_budget(phase_budget[p]);
      steady = (p == 2);
      n = 0;
      while (n < PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        v.req = roll < 50 ? REQ_ADD : roll < 78 ? REQ_LOOKUP :
                roll < 95 ? REQ_REMOVE : REQ_UNKNOWN;
        v.idx = SLOT_W'($urandom_range(0, ENTRIES - 1));
        v.ident = ($urandom_range(0, 1) == 1) ? cached_ident[v.idx] : $urandom;
        v.size = pick_size(budget_now);
        v.handle = $urandom;
        v.typed = 1'b0;
        v.want = NO_WANT;
        offer(v);
        if (v.req != REQ_UNKNOWN) n++;
      end
      settle();
    end
    steady = 1'b0;
    $display("tb_top: %0d requests, %0d result words, six budget settings from zero to full scale",
             requests_sent, words_checked);
    $display("tb_top: covered whole-ring evictions, unknown request codes and a %0d-cycle stall",
             HOLD_CYCLES);
    if (failures == 0 && expected_words.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
